### rtl/core/aum_pkg.sv
// ----------------------------------------------------------------------------
// aum_pkg
// Shared types and constants of the allocation usage monitor.
// ----------------------------------------------------------------------------
package aum_pkg;

  localparam int unsigned CNT_W   = 32;
  localparam int unsigned BYTE_W  = 40;
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned CLASS_W = 4;
  localparam int unsigned FRAG_W  = 7;
  localparam int unsigned CFG_W   = 2;

  localparam logic [BYTE_W-1:0] THR_LOW_RST   = BYTE_W'(8 * 1024 * 1024);
  localparam logic [BYTE_W-1:0] THR_CRIT_RST  = BYTE_W'(4 * 1024 * 1024);
  localparam logic [SIZE_W-1:0] LARGE_RST     = SIZE_W'(4096);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_FAIL  = 2'd2,
    OP_QUERY = 2'd3
  } aum_op_e;

  typedef enum logic [CFG_W-1:0] {
    CFG_THR_LOW  = 2'd0,
    CFG_THR_CRIT = 2'd1,
    CFG_LARGE    = 2'd2
  } aum_cfg_e;

  // one classified event word handed from front to back
  typedef struct packed {
    aum_op_e             op;
    logic [CLASS_W-1:0]  cls;
    logic [SIZE_W-1:0]   size;
    logic [FRAG_W-1:0]   frag;
    logic                is_big;
  } aum_item_t;

endpackage

### rtl/core/aum_front.sv
// ----------------------------------------------------------------------------
// aum_front
// Accepts event words, folds out-of-range classes onto class 0 and flags
// large requests before they are queued.
// ----------------------------------------------------------------------------
module aum_front import aum_pkg::*; #(
  parameter int unsigned NUM_CLASSES = 7
) (
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          opcode_i,
  input  logic [CLASS_W-1:0]  mem_class_i,
  input  logic [SIZE_W-1:0]   size_bytes_i,
  input  logic [FRAG_W-1:0]   frag_percent_i,
  input  logic [SIZE_W-1:0]   large_size_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output aum_item_t           q_item_o
);

  logic out_of_range;

  assign out_of_range = {1'b0, mem_class_i} >= (CLASS_W + 1)'(NUM_CLASSES);

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o.op     = aum_op_e'(opcode_i);
    q_item_o.cls    = out_of_range ? '0 : mem_class_i;
    q_item_o.size   = size_bytes_i;
    q_item_o.frag   = frag_percent_i;
    q_item_o.is_big = size_bytes_i > large_size_i;
  end

endmodule

### rtl/core/aum_fifo.sv
// ----------------------------------------------------------------------------
// aum_fifo
// Two-word queue between the front and the back.
// ----------------------------------------------------------------------------
module aum_fifo import aum_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  aum_item_t  item_i,
  output logic       full_o,
  input  logic       pop_i,
  output aum_item_t  item_o,
  output logic       empty_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  aum_item_t            mem_q [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]       count_q;

  assign full_o  = count_q == (PTR_W + 1)'(DEPTH);
  assign empty_o = count_q == '0;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### rtl/core/aum_back.sv
// ----------------------------------------------------------------------------
// aum_back
// Carries out queued events on the class table and the totals, then
// evaluates pressure and loads the result register.
// ----------------------------------------------------------------------------
module aum_back import aum_pkg::*; #(
  parameter int unsigned NUM_CLASSES = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  aum_item_t          q_item_i,
  output logic               q_pop_o,
  input  logic [BYTE_W-1:0]  thr_low_i,
  input  logic [BYTE_W-1:0]  thr_crit_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CNT_W-1:0]   class_allocs_o,
  output logic [CNT_W-1:0]   class_frees_o,
  output logic [BYTE_W-1:0]  class_current_o,
  output logic [BYTE_W-1:0]  class_peak_o,
  output logic [CNT_W-1:0]   class_failed_o,
  output logic [CNT_W-1:0]   class_large_o,
  output logic [BYTE_W-1:0]  total_bytes_o,
  output logic [BYTE_W-1:0]  total_peak_o,
  output logic [CNT_W-1:0]   total_failed_o,
  output logic [CNT_W-1:0]   warning_count_o,
  output logic [CNT_W-1:0]   oom_count_o,
  output logic               pressure_o
);

  localparam int unsigned CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam logic [CNT_W-1:0]  FAIL_LIMIT = CNT_W'(10);
  localparam logic [FRAG_W-1:0] FRAG_LIMIT = FRAG_W'(60);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_PEAK,
    S_OUT
  } state_e;

  function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [BYTE_W-1:0] add_bytes(input logic [BYTE_W-1:0] a,
                                                  input logic [SIZE_W-1:0] b);
    logic [BYTE_W:0] s;
    s = {1'b0, a} + (BYTE_W + 1)'(b);
    return s[BYTE_W] ? {BYTE_W{1'b1}} : s[BYTE_W-1:0];
  endfunction

  function automatic logic [BYTE_W-1:0] sub_floor(input logic [BYTE_W-1:0] a,
                                                  input logic [SIZE_W-1:0] b);
    logic [BYTE_W:0] d;
    d = {1'b0, a} - (BYTE_W + 1)'(b);
    return d[BYTE_W] ? '0 : d[BYTE_W-1:0];
  endfunction

  state_e              state_q;
  aum_item_t           item_q;

  logic [CNT_W-1:0]    ca_q  [NUM_CLASSES];
  logic [CNT_W-1:0]    cf_q  [NUM_CLASSES];
  logic [BYTE_W-1:0]   cc_q  [NUM_CLASSES];
  logic [BYTE_W-1:0]   cp_q  [NUM_CLASSES];
  logic [CNT_W-1:0]    cfl_q [NUM_CLASSES];
  logic [CNT_W-1:0]    cl_q  [NUM_CLASSES];

  logic [BYTE_W-1:0]   tot_cur_q, tot_peak_q;
  logic [CNT_W-1:0]    tot_alloc_q, tot_fail_q, warn_q, oom_q;

  logic [CLS_W-1:0]    c;
  logic [CNT_W-1:0]    rd_ca, rd_cf, rd_cfl, rd_cl;
  logic [BYTE_W-1:0]   rd_cc, rd_cp;

  logic                hi_use, hi_fail, hi_frag, pressure_d;
  logic [CNT_W+6:0]    fail_x100;
  logic [CNT_W+6:0]    alloc_x6;
  logic                load_out;

  assign c      = item_q.cls[CLS_W-1:0];
  assign rd_ca  = ca_q[c];
  assign rd_cf  = cf_q[c];
  assign rd_cc  = cc_q[c];
  assign rd_cp  = cp_q[c];
  assign rd_cfl = cfl_q[c];
  assign rd_cl  = cl_q[c];

  // x100 = x64 + x32 + x4, x6 = x4 + x2
  assign fail_x100 = {1'b0, tot_fail_q, 6'b0} + {2'b0, tot_fail_q, 5'b0}
                   + {5'b0, tot_fail_q, 2'b0};
  assign alloc_x6  = {5'b0, tot_alloc_q, 2'b0} + {6'b0, tot_alloc_q, 1'b0};

  always_comb begin
    hi_use     = tot_cur_q > thr_low_i;
    hi_fail    = (tot_fail_q > FAIL_LIMIT) && (tot_alloc_q != '0)
               && (fail_x100 >= alloc_x6);
    hi_frag    = item_q.frag > FRAG_LIMIT;
    pressure_d = (tot_cur_q > thr_crit_i) || (hi_use && hi_fail)
               || (hi_use && hi_frag) || (hi_fail && hi_frag);
  end

  assign q_pop_o  = (state_q == S_IDLE) && !q_empty_i;
  assign load_out = (state_q == S_OUT) && (!out_valid_o || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_q      <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        ca_q[i]  <= '0;
        cf_q[i]  <= '0;
        cc_q[i]  <= '0;
        cp_q[i]  <= '0;
        cfl_q[i] <= '0;
        cl_q[i]  <= '0;
      end
      tot_cur_q       <= '0;
      tot_peak_q      <= '0;
      tot_alloc_q     <= '0;
      tot_fail_q      <= '0;
      warn_q          <= '0;
      oom_q           <= '0;
      out_valid_o     <= 1'b0;
      class_allocs_o  <= '0;
      class_frees_o   <= '0;
      class_current_o <= '0;
      class_peak_o    <= '0;
      class_failed_o  <= '0;
      class_large_o   <= '0;
      total_bytes_o   <= '0;
      total_peak_o    <= '0;
      total_failed_o  <= '0;
      warning_count_o <= '0;
      oom_count_o     <= '0;
      pressure_o      <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i && !load_out) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            item_q  <= q_item_i;
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          case (item_q.op)
            OP_ALLOC: begin
              ca_q[c]     <= inc_sat(rd_ca);
              cc_q[c]     <= add_bytes(rd_cc, item_q.size);
              if (item_q.is_big) begin
                cl_q[c] <= inc_sat(rd_cl);
              end
              tot_alloc_q <= inc_sat(tot_alloc_q);
              tot_cur_q   <= add_bytes(tot_cur_q, item_q.size);
            end
            OP_FREE: begin
              cf_q[c]   <= inc_sat(rd_cf);
              cc_q[c]   <= sub_floor(rd_cc, item_q.size);
              tot_cur_q <= sub_floor(tot_cur_q, item_q.size);
            end
            OP_FAIL: begin
              cfl_q[c]   <= inc_sat(rd_cfl);
              tot_fail_q <= inc_sat(tot_fail_q);
            end
            default: ;
          endcase
          state_q <= S_PEAK;
        end
        S_PEAK: begin
          // peaks and event counters follow the updated totals
          case (item_q.op)
            OP_ALLOC: begin
              if (rd_cc > rd_cp) begin
                cp_q[c] <= rd_cc;
              end
              if (tot_cur_q > tot_peak_q) begin
                tot_peak_q <= tot_cur_q;
              end
              if (tot_cur_q > thr_low_i) begin
                warn_q <= inc_sat(warn_q);
              end
            end
            OP_FAIL: begin
              if (item_q.is_big || (tot_fail_q > FAIL_LIMIT)) begin
                oom_q <= inc_sat(oom_q);
              end
            end
            default: ;
          endcase
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (load_out) begin
            out_valid_o     <= 1'b1;
            class_allocs_o  <= rd_ca;
            class_frees_o   <= rd_cf;
            class_current_o <= rd_cc;
            class_peak_o    <= rd_cp;
            class_failed_o  <= rd_cfl;
            class_large_o   <= rd_cl;
            total_bytes_o   <= tot_cur_q;
            total_peak_o    <= tot_peak_q;
            total_failed_o  <= tot_fail_q;
            warning_count_o <= warn_q;
            oom_count_o     <= oom_q;
            pressure_o      <= pressure_d;
            state_q         <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/alloc_usage_monitor.sv
// ----------------------------------------------------------------------------
// alloc_usage_monitor
// Per-class and total allocation counters with warning, out-of-memory and
// pressure reporting.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one event word (opcode,
// mem_class, size_bytes, frag_percent). Output channel: out_valid_o /
// out_stall_i carry one result word per event, in order. A word moves on a
// rising edge with valid high and stall low.
// Thresholds and the large size are written on cfg_we_i with cfg_idx_i
// 0 low threshold, 1 critical threshold, 2 large size; other indexes are
// ignored. Write only while no event is in flight.
// An accepted event sits in a two-word queue; the back end then takes it
// through its steps in order (pop, table update, peak and event counters,
// result load) and pops the next event only after the result is loaded,
// so the back-end sequencer handles one event at a time.
// Reset clears every counter and restores the register defaults.
// While the receiver stalls the result register holds, the back end waits
// and the queue fills; in_stall_o rises once both queue words are taken.
// ----------------------------------------------------------------------------
module alloc_usage_monitor import aum_pkg::*; #(
  parameter int unsigned NUM_CLASSES = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_idx_i,
  input  logic [BYTE_W-1:0]  cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic [CLASS_W-1:0] mem_class_i,
  input  logic [SIZE_W-1:0]  size_bytes_i,
  input  logic [FRAG_W-1:0]  frag_percent_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CNT_W-1:0]   class_allocs_o,
  output logic [CNT_W-1:0]   class_frees_o,
  output logic [BYTE_W-1:0]  class_current_o,
  output logic [BYTE_W-1:0]  class_peak_o,
  output logic [CNT_W-1:0]   class_failed_o,
  output logic [CNT_W-1:0]   class_large_o,
  output logic [BYTE_W-1:0]  total_bytes_o,
  output logic [BYTE_W-1:0]  total_peak_o,
  output logic [CNT_W-1:0]   total_failed_o,
  output logic [CNT_W-1:0]   warning_count_o,
  output logic [CNT_W-1:0]   oom_count_o,
  output logic               pressure_o
);

  logic [BYTE_W-1:0] thr_low_q, thr_crit_q;
  logic [SIZE_W-1:0] large_q;

  logic      q_push, q_pop, q_full, q_empty;
  aum_item_t q_in, q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_low_q  <= THR_LOW_RST;
      thr_crit_q <= THR_CRIT_RST;
      large_q    <= LARGE_RST;
    end else if (cfg_we_i) begin
      case (aum_cfg_e'(cfg_idx_i))
        CFG_THR_LOW:  thr_low_q  <= cfg_data_i;
        CFG_THR_CRIT: thr_crit_q <= cfg_data_i;
        CFG_LARGE:    large_q    <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  aum_front #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .mem_class_i    (mem_class_i),
    .size_bytes_i   (size_bytes_i),
    .frag_percent_i (frag_percent_i),
    .large_size_i   (large_q),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_item_o       (q_in)
  );

  aum_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_out),
    .empty_o (q_empty)
  );

  aum_back #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_item_i        (q_out),
    .q_pop_o         (q_pop),
    .thr_low_i       (thr_low_q),
    .thr_crit_i      (thr_crit_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .class_allocs_o  (class_allocs_o),
    .class_frees_o   (class_frees_o),
    .class_current_o (class_current_o),
    .class_peak_o    (class_peak_o),
    .class_failed_o  (class_failed_o),
    .class_large_o   (class_large_o),
    .total_bytes_o   (total_bytes_o),
    .total_peak_o    (total_peak_o),
    .total_failed_o  (total_failed_o),
    .warning_count_o (warning_count_o),
    .oom_count_o     (oom_count_o),
    .pressure_o      (pressure_o)
  );

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for alloc_usage_monitor: drives allocate, free, failed
// allocate and query words with random idling and back-pressure on both
// channels, predicts every result word in-bench and compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import aum_pkg::*;

  localparam int unsigned NUM_CLS     = 7;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_GAP     = 12;
  localparam int unsigned FAIL_BURST  = 10;
  localparam int unsigned RATE_SCALE  = 100;
  localparam int unsigned RATE_PCT    = 6;
  localparam int unsigned FRAG_HIGH   = 60;
  localparam logic [CFG_W-1:0]  CFG_SPARE = 2'd3;
  localparam logic [BYTE_W-1:0] BYTE_TOP  = '1;
  localparam logic [SIZE_W-1:0] SIZE_TOP  = '1;

  typedef struct {
    logic [CNT_W-1:0]  allocs;
    logic [CNT_W-1:0]  frees;
    logic [BYTE_W-1:0] cur;
    logic [BYTE_W-1:0] peak;
    logic [CNT_W-1:0]  failed;
    logic [CNT_W-1:0]  big;
    logic [BYTE_W-1:0] tot_cur;
    logic [BYTE_W-1:0] tot_peak;
    logic [CNT_W-1:0]  tot_failed;
    logic [CNT_W-1:0]  warns;
    logic [CNT_W-1:0]  ooms;
    logic              pressure;
  } usage_report_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CFG_W-1:0]   cfg_idx = '0;
  logic [BYTE_W-1:0]  cfg_data = '0;
  logic               in_valid = 1'b0;
  logic [1:0]         opcode = OP_QUERY;
  logic [CLASS_W-1:0] mem_class = '0;
  logic [SIZE_W-1:0]  size_bytes = '0;
  logic [FRAG_W-1:0]  frag_percent = '0;
  logic               out_stall = 1'b0;

  logic               in_stall_o;
  logic               out_valid_o;
  logic [CNT_W-1:0]   class_allocs_o;
  logic [CNT_W-1:0]   class_frees_o;
  logic [BYTE_W-1:0]  class_current_o;
  logic [BYTE_W-1:0]  class_peak_o;
  logic [CNT_W-1:0]   class_failed_o;
  logic [CNT_W-1:0]   class_large_o;
  logic [BYTE_W-1:0]  total_bytes_o;
  logic [BYTE_W-1:0]  total_peak_o;
  logic [CNT_W-1:0]   total_failed_o;
  logic [CNT_W-1:0]   warning_count_o;
  logic [CNT_W-1:0]   oom_count_o;
  logic               pressure_o;

  // predicted block state
  logic [CNT_W-1:0]  cls_allocs [NUM_CLS] = '{default: '0};
  logic [CNT_W-1:0]  cls_frees  [NUM_CLS] = '{default: '0};
  logic [BYTE_W-1:0] cls_cur    [NUM_CLS] = '{default: '0};
  logic [BYTE_W-1:0] cls_peak   [NUM_CLS] = '{default: '0};
  logic [CNT_W-1:0]  cls_failed [NUM_CLS] = '{default: '0};
  logic [CNT_W-1:0]  cls_big    [NUM_CLS] = '{default: '0};
  logic [BYTE_W-1:0] tot_cur    = '0;
  logic [BYTE_W-1:0] tot_peak   = '0;
  logic [CNT_W-1:0]  tot_allocs = '0;
  logic [CNT_W-1:0]  tot_failed = '0;
  logic [CNT_W-1:0]  warn_cnt   = '0;
  logic [CNT_W-1:0]  oom_cnt    = '0;
  logic [BYTE_W-1:0] thr_low    = THR_LOW_RST;
  logic [BYTE_W-1:0] thr_crit   = THR_CRIT_RST;
  logic [SIZE_W-1:0] big_size   = LARGE_RST;

  usage_report_t pending_reports [$];
  int unsigned   fault_cnt  = 0;
  int unsigned   cycle_cnt  = 0;
  int unsigned   hold_req   = 0;
  int unsigned   stall_left = 0;
  bit            idle_on    = 1'b1;

  alloc_usage_monitor #(
    .NUM_CLASSES(NUM_CLS)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode),
    .mem_class_i    (mem_class),
    .size_bytes_i   (size_bytes),
    .frag_percent_i (frag_percent),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .class_allocs_o (class_allocs_o),
    .class_frees_o  (class_frees_o),
    .class_current_o(class_current_o),
    .class_peak_o   (class_peak_o),
    .class_failed_o (class_failed_o),
    .class_large_o  (class_large_o),
    .total_bytes_o  (total_bytes_o),
    .total_peak_o   (total_peak_o),
    .total_failed_o (total_failed_o),
    .warning_count_o(warning_count_o),
    .oom_count_o    (oom_count_o),
    .pressure_o     (pressure_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("** alloc_usage_monitor: FAILED **");
      $finish;
    end
  end

  function automatic logic [CNT_W-1:0] cnt_inc(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [BYTE_W-1:0] bytes_add(logic [BYTE_W-1:0] a,
                                                  logic [SIZE_W-1:0] b);
    logic [BYTE_W:0] s;
    s = {1'b0, a} + (BYTE_W + 1)'(b);
    return s[BYTE_W] ? BYTE_TOP : s[BYTE_W-1:0];
  endfunction

  function automatic logic [BYTE_W-1:0] bytes_sub(logic [BYTE_W-1:0] a,
                                                  logic [SIZE_W-1:0] b);
    return (a >= b) ? a - b : '0;
  endfunction

  // applies one event to the predicted state and queues the result word
  task automatic account_event(aum_op_e op, logic [CLASS_W-1:0] cls_in,
                               logic [SIZE_W-1:0] nbytes, logic [FRAG_W-1:0] frag);
    int unsigned   c;
    bit            use_hi;
    bit            fail_hi;
    bit            frag_hi;
    int unsigned   votes;
    usage_report_t r;
    c = (cls_in >= NUM_CLS) ? 0 : cls_in;
    case (op)
      OP_ALLOC: begin
        cls_allocs[c] = cnt_inc(cls_allocs[c]);
        cls_cur[c] = bytes_add(cls_cur[c], nbytes);
        if (cls_cur[c] > cls_peak[c]) cls_peak[c] = cls_cur[c];
        if (nbytes > big_size) cls_big[c] = cnt_inc(cls_big[c]);
        tot_allocs = cnt_inc(tot_allocs);
        tot_cur = bytes_add(tot_cur, nbytes);
        if (tot_cur > tot_peak) tot_peak = tot_cur;
        if (tot_cur > thr_low) warn_cnt = cnt_inc(warn_cnt);
      end
      OP_FREE: begin
        cls_frees[c] = cnt_inc(cls_frees[c]);
        cls_cur[c] = bytes_sub(cls_cur[c], nbytes);
        tot_cur = bytes_sub(tot_cur, nbytes);
      end
      OP_FAIL: begin
        cls_failed[c] = cnt_inc(cls_failed[c]);
        tot_failed = cnt_inc(tot_failed);
        if (nbytes > big_size || tot_failed > FAIL_BURST) oom_cnt = cnt_inc(oom_cnt);
      end
      default: ;
    endcase
    use_hi  = tot_cur > thr_low;
    // failure rate of at least six percent, kept exact in 64 bits
    fail_hi = tot_failed > FAIL_BURST && tot_allocs != 0 &&
              longint'(tot_failed) * RATE_SCALE >= longint'(tot_allocs) * RATE_PCT;
    frag_hi = frag > FRAG_HIGH;
    votes   = use_hi + fail_hi + frag_hi;
    r.allocs     = cls_allocs[c];
    r.frees      = cls_frees[c];
    r.cur        = cls_cur[c];
    r.peak       = cls_peak[c];
    r.failed     = cls_failed[c];
    r.big        = cls_big[c];
    r.tot_cur    = tot_cur;
    r.tot_peak   = tot_peak;
    r.tot_failed = tot_failed;
    r.warns      = warn_cnt;
    r.ooms       = oom_cnt;
    r.pressure   = (tot_cur > thr_crit) || (votes >= 2);
    pending_reports.push_back(r);
  endtask

  task automatic check_field(string name, logic [BYTE_W-1:0] want_v,
                             logic [BYTE_W-1:0] got_v);
    if (got_v !== want_v) begin
      if (fault_cnt < 10)
        $display("%0t: %s expected %0h, got %0h", $time, name, want_v, got_v);
      fault_cnt++;
    end
  endtask

  // result word checker
  always @(posedge clk) begin
    usage_report_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (pending_reports.size() == 0) begin
        if (fault_cnt < 10) $display("%0t: result word with nothing expected", $time);
        fault_cnt++;
      end else begin
        want = pending_reports.pop_front();
        check_field("class_allocs", want.allocs, class_allocs_o);
        check_field("class_frees", want.frees, class_frees_o);
        check_field("class_current", want.cur, class_current_o);
        check_field("class_peak", want.peak, class_peak_o);
        check_field("class_failed", want.failed, class_failed_o);
        check_field("class_large", want.big, class_large_o);
        check_field("total_bytes", want.tot_cur, total_bytes_o);
        check_field("total_peak", want.tot_peak, total_peak_o);
        check_field("total_failed", want.tot_failed, total_failed_o);
        check_field("warning_count", want.warns, warning_count_o);
        check_field("oom_count", want.ooms, oom_count_o);
        check_field("pressure", want.pressure, pressure_o);
      end
    end
  end

  // receiver: random stall after each word while idling is on, or a long hold when requested
  always @(posedge clk) begin
    if (hold_req != 0) begin
      stall_left = hold_req;
      hold_req = 0;
    end else if (out_valid_o && !out_stall) begin
      stall_left = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    end
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_event(aum_op_e op, logic [CLASS_W-1:0] cls_in,
                            logic [SIZE_W-1:0] nbytes, logic [FRAG_W-1:0] frag);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    mem_class    <= cls_in;
    size_bytes   <= nbytes;
    frag_percent <= frag;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    account_event(op, cls_in, nbytes, frag);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic write_reg(logic [CFG_W-1:0] idx, logic [BYTE_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
    case (idx)
      CFG_THR_LOW:  thr_low  = data;
      CFG_THR_CRIT: thr_crit = data;
      CFG_LARGE:    big_size = data[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 8191);
      4:          return big_size + $urandom_range(0, 1);
      5:          return '0;
      6:          return SIZE_TOP;
      7:          return $urandom;
      default:    return $urandom_range(0, 1 << 20);
    endcase
  endfunction

  task automatic send_random();
    aum_op_e           op;
    int unsigned       pick;
    logic [FRAG_W-1:0] frag;
    pick = $urandom_range(0, 19);
    if (pick < 8)       op = OP_ALLOC;
    else if (pick < 13) op = OP_FREE;
    else if (pick < 17) op = OP_FAIL;
    else                op = OP_QUERY;
    frag = $urandom_range(0, 1) ? FRAG_W'($urandom_range(0, 127))
                                : FRAG_W'($urandom_range(55, 65));
    send_event(op, CLASS_W'($urandom_range(0, 15)), pick_size(), frag);
  endtask

  task automatic test_directed();
    send_event(OP_QUERY, 4'd0, 32'd0, 7'd0);
    send_event(OP_ALLOC, 4'd1, 32'd4096, 7'd60);
    send_event(OP_ALLOC, 4'd1, 32'd4097, 7'd61);
    send_event(OP_ALLOC, 4'd6, SIZE_TOP, 7'd127);
    send_event(OP_FREE, 4'd6, 32'd100, 7'd101);
    // free on an empty class stops at zero
    send_event(OP_FREE, 4'd2, 32'd5, 7'd0);
    // classes past the end fold onto class 0
    send_event(OP_ALLOC, 4'd7, 32'd1, 7'd30);
    send_event(OP_ALLOC, 4'd15, 32'd2, 7'd30);
    send_event(OP_QUERY, 4'd9, 32'd77, 7'd30);
    send_event(OP_FREE, 4'd6, SIZE_TOP, 7'd0);
    send_event(OP_FAIL, 4'd3, 32'd4097, 7'd0);
    // failure burst trips out-of-memory and the failure-rate vote
    repeat (11) send_event(OP_FAIL, 4'd4, 32'd0, 7'd10);
    send_event(OP_QUERY, 4'd0, 32'd0, 7'd61);
    send_event(OP_QUERY, 4'd5, 32'd0, 7'd0);
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_req = 150;
    repeat (30) send_random();
    wait_idle();
    repeat (20) send_random();
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 60 == 0) idle_on = ($urandom_range(0, 3) != 0);
      send_random();
    end
    idle_on = 1'b1;
  endtask

  task automatic test_config_sweep();
    wait_idle();
    write_reg(CFG_THR_LOW, '0);
    write_reg(CFG_THR_CRIT, BYTE_TOP);
    write_reg(CFG_LARGE, '0);
    // unused index must leave every register alone
    write_reg(CFG_SPARE, {8'($urandom), 32'($urandom)});
    test_random_traffic(100);
    wait_idle();
    write_reg(CFG_THR_LOW, BYTE_TOP);
    write_reg(CFG_THR_CRIT, '0);
    // upper data bits fall away on the 32-bit register
    write_reg(CFG_LARGE, {8'hA5, SIZE_TOP});
    test_random_traffic(100);
    wait_idle();
    write_reg(CFG_THR_LOW, BYTE_W'($urandom_range(1 << 16, 1 << 26)));
    write_reg(CFG_THR_CRIT, BYTE_W'($urandom_range(1 << 16, 1 << 28)));
    write_reg(CFG_LARGE, BYTE_W'($urandom_range(0, 65535)));
    test_random_traffic(100);
  endtask

  task automatic test_byte_saturation();
    int unsigned pick;
    wait_idle();
    write_reg(CFG_THR_LOW, BYTE_TOP);
    write_reg(CFG_THR_CRIT, BYTE_TOP);
    write_reg(CFG_LARGE, BYTE_W'($urandom));
    // enough near-full words into class 0 to pin both byte counts at the top
    for (int unsigned i = 0; i < 270; i++) begin
      pick = $urandom_range(0, 9);
      send_event(OP_ALLOC, (pick == 0) ? 4'd0 : CLASS_W'(pick + 6),
                 $urandom_range(32'hFFF0_0000, SIZE_TOP),
                 FRAG_W'($urandom_range(0, 127)));
    end
    for (int unsigned i = 0; i < 40; i++)
      send_event(($urandom_range(0, 3) == 0) ? OP_QUERY : OP_FREE,
                 CLASS_W'($urandom_range(0, 15)),
                 $urandom, FRAG_W'($urandom_range(0, 127)));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random_traffic(350);
    test_config_sweep();
    test_byte_saturation();
    wait_idle();
    repeat (20) @(posedge clk);
    if (fault_cnt == 0) begin
      $display("** alloc_usage_monitor: PASSED **");
    end else begin
      $display("** alloc_usage_monitor: FAILED **");
    end
    $finish;
  end

endmodule
